FILE: rtl/rkc_pkg.sv
// Package for the running-key shift cipher: character codes, register
// indexes, item kinds and the beat payload types of both channels.
// No dependencies; the cipher module running_key_shift_cipher uses it.
package rkc_pkg;

    // Letters in the alphabet; key offsets are kept below this value.
    localparam int unsigned ALPHA = 26;

    // Key table depth used when the top level is not told otherwise.
    localparam int unsigned KEY_DEPTH_DEFAULT = 256;

    // Character codes.
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CASE_OFFSET  = CHAR_LOWER_A - CHAR_UPPER_A;

    // Reciprocal of 26 scaled by 2**20, rounded up; exact for 16-bit words.
    localparam int unsigned RECIP_SHIFT = 20;
    localparam logic [15:0] RECIP_26    = 16'd40330;

    // Configuration port.
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 9;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_LENGTH   = 1'b0,
        REG_DECRYPT_MODE = 1'b1
    } rkc_reg_t;

    typedef enum logic {
        KIND_TEXT = 1'b0,
        KIND_KEY  = 1'b1
    } rkc_kind_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  text_byte;
        logic [7:0]  key_slot;
        logic [15:0] key_value;
    } rkc_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
    } rkc_result_t;

endpackage

FILE: rtl/rkc_stream_if.sv
// Valid/ready stream interface carrying one payload beat per handshake.
// Depends on nothing; the payload type is handed in by the user.
interface rkc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/running_key_shift_cipher.sv
// Running-key shift cipher: key table memory, key position tracking and
// the letter shift datapath in a two-register pipeline.
// Depends on rkc_pkg and rkc_stream_if.
//
// Usage. Beats arrive on the items channel (a sink of rkc_stream_if)
// and results leave on the results channel (a source). A beat of kind
// key writes one offset, reduced modulo 26, into the key table and gives
// no result. A beat of kind text gives exactly one result beat. Space,
// LF and CR pass through and leave the key position alone; every other
// byte takes the offset at the key position, which then moves on and
// wraps after key_length positions. Letters of either case come out in
// upper case, shifted forward or, with decrypt_mode set, backward.
// A text beat passes through the first-stage register and then the
// result register. The block takes one beat per cycle while the receiver
// takes results. When the receiver stalls, the result register holds and
// the stage behind it fills; ready then drops until the result is taken.
// Reset empties the pipeline, sets the key position to zero, key_length to
// 1 and decrypt_mode to 0. The key table is not cleared: entries must be
// written before text uses them.
module running_key_shift_cipher #(
    parameter int unsigned KEY_DEPTH = rkc_pkg::KEY_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rkc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rkc_pkg::CFG_DATA_W-1:0]   cfg_data,
    rkc_stream_if.sink                       items,
    rkc_stream_if.source                     results
);

    // Address width of the key table, width of an effective length, and a
    // common width for comparing lengths and positions.
    localparam int unsigned AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int unsigned LW = $clog2(KEY_DEPTH + 1);
    localparam int unsigned CW = (LW > rkc_pkg::CFG_DATA_W) ? LW : rkc_pkg::CFG_DATA_W;
    localparam int unsigned SW = AW + 8;

    // ------------------------------------------------------------------
    // Configuration registers. The key length is stored already clamped
    // to 1..KEY_DEPTH so the position logic sees only a legal value.
    // ------------------------------------------------------------------
    logic [CW-1:0] len_eff_reg;
    logic [CW-1:0] len_eff_next;
    logic          decrypt_reg;
    logic [CW-1:0] len_raw;

    always_comb
    begin
        len_raw = CW'(cfg_data);
        if (len_raw == '0)
            len_eff_next = CW'(1);
        else if (len_raw > CW'(KEY_DEPTH))
            len_eff_next = CW'(KEY_DEPTH);
        else
            len_eff_next = len_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_eff_reg <= CW'(1);
            decrypt_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (rkc_pkg::rkc_reg_t'(cfg_index))
                rkc_pkg::REG_KEY_LENGTH:   len_eff_reg <= len_eff_next;
                rkc_pkg::REG_DECRYPT_MODE: decrypt_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The first stage moves on when the result register is
    // empty or is being emptied, so a new beat can enter every cycle while results are taken.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s1_advance;
    logic accept;

    assign s1_advance  = !out_valid_reg || results.ready;
    assign items.ready = !s1_valid_reg || s1_advance;
    assign accept      = items.valid && items.ready;

    // ------------------------------------------------------------------
    // Input decode and key position.
    // ------------------------------------------------------------------
    logic          is_text;
    logic          is_sep;
    logic          key_use;
    logic [SW-1:0] slot_ext;
    logic          slot_ok;
    logic          key_wr;
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] pos_next;
    logic [CW-1:0] pos_cur;
    logic [CW-1:0] pos_inc;
    logic [CW-1:0] pos_adv;
    logic [AW-1:0] rd_addr;

    assign is_text = (rkc_pkg::rkc_kind_t'(items.data.kind) == rkc_pkg::KIND_TEXT);
    assign is_sep  = (items.data.text_byte == rkc_pkg::CHAR_SPACE) ||
                     (items.data.text_byte == rkc_pkg::CHAR_LF) ||
                     (items.data.text_byte == rkc_pkg::CHAR_CR);
    assign key_use = accept && is_text && !is_sep;

    // Writes to slots beyond the table are dropped.
    assign slot_ext = SW'(items.data.key_slot);
    assign slot_ok  = slot_ext < SW'(KEY_DEPTH);
    assign key_wr   = accept && !is_text && slot_ok;

    // A position left past a shortened length restarts at zero before use;
    // after use it advances and wraps at the length.
    always_comb
    begin
        pos_cur  = (CW'(pos_reg) >= len_eff_reg) ? '0 : CW'(pos_reg);
        pos_inc  = pos_cur + CW'(1);
        pos_adv  = (pos_inc >= len_eff_reg) ? '0 : pos_inc;
        rd_addr  = pos_cur[AW-1:0];
        pos_next = key_use ? pos_adv[AW-1:0] : pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

    // ------------------------------------------------------------------
    // Key write path. The quotient by 26 comes from a reciprocal multiply
    // in the accepting cycle; only its low five bits are kept, which is
    // all the remainder needs. The table write lands in the next cycle.
    // ------------------------------------------------------------------
    logic [31:0]   quot_prod;
    logic          wr_pend_valid_reg;
    logic [AW-1:0] wr_slot_reg;
    logic [4:0]    wr_q5_reg;
    logic [4:0]    wr_v5_reg;
    logic [4:0]    wr_key;

    assign quot_prod = 32'(items.data.key_value) * 32'(rkc_pkg::RECIP_26);
    assign wr_key    = wr_v5_reg - 5'(wr_q5_reg * 5'(rkc_pkg::ALPHA));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_pend_valid_reg <= 1'b0;
        else
            wr_pend_valid_reg <= key_wr;
    end

    always_ff @(posedge clk)
    begin
        if (key_wr)
        begin
            wr_slot_reg <= slot_ext[AW-1:0];
            wr_q5_reg   <= quot_prod[rkc_pkg::RECIP_SHIFT +: 5];
            wr_v5_reg   <= items.data.key_value[4:0];
        end
    end

    // ------------------------------------------------------------------
    // Key table memory with a registered read. A read that meets the
    // pending write to the same entry takes the written value instead.
    // ------------------------------------------------------------------
    logic [4:0] key_mem [KEY_DEPTH];
    logic [4:0] rd_data_reg;
    logic       byp_hit_reg;
    logic [4:0] byp_key_reg;

    always_ff @(posedge clk)
    begin
        if (wr_pend_valid_reg)
            key_mem[wr_slot_reg] <= wr_key;
        if (key_use)
        begin
            rd_data_reg <= key_mem[rd_addr];
            byp_hit_reg <= wr_pend_valid_reg && (wr_slot_reg == rd_addr);
            byp_key_reg <= wr_key;
        end
    end

    // ------------------------------------------------------------------
    // First stage: the text byte, waiting for its key offset.
    // ------------------------------------------------------------------
    logic [7:0] s1_byte_reg;
    logic       s1_next_valid;

    assign s1_next_valid = (accept && is_text) || (s1_valid_reg && !s1_advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_next_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_text)
            s1_byte_reg <= items.data.text_byte;
    end

    // ------------------------------------------------------------------
    // Letter shift. Lower case folds to upper case; separators and other
    // non-letters leave as they came.
    // ------------------------------------------------------------------
    logic [4:0] key_off;
    logic       is_lower;
    logic [7:0] ch_up;
    logic       is_letter;
    logic [4:0] letter;
    logic [5:0] shift_sum;
    logic [5:0] shift_red;
    logic [7:0] res_byte;

    always_comb
    begin
        key_off   = byp_hit_reg ? byp_key_reg : rd_data_reg;
        is_lower  = (s1_byte_reg >= rkc_pkg::CHAR_LOWER_A) &&
                    (s1_byte_reg <= rkc_pkg::CHAR_LOWER_Z);
        ch_up     = is_lower ? (s1_byte_reg - rkc_pkg::CASE_OFFSET) : s1_byte_reg;
        is_letter = (ch_up >= rkc_pkg::CHAR_UPPER_A) && (ch_up <= rkc_pkg::CHAR_UPPER_Z);
        letter    = 5'(ch_up - rkc_pkg::CHAR_UPPER_A);
        if (decrypt_reg)
            shift_sum = 6'(letter) + 6'(rkc_pkg::ALPHA) - 6'(key_off);
        else
            shift_sum = 6'(letter) + 6'(key_off);
        shift_red = (shift_sum >= 6'(rkc_pkg::ALPHA)) ?
                    (shift_sum - 6'(rkc_pkg::ALPHA)) : shift_sum;
        res_byte  = is_letter ? (8'(shift_red) + rkc_pkg::CHAR_UPPER_A) : s1_byte_reg;
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic [7:0] out_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
            out_byte_reg <= res_byte;
    end

    assign results.valid         = out_valid_reg;
    assign results.data.out_byte = out_byte_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A result only appears after the first stage held a text beat.
    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result valid rose without a text beat in the first stage");

    // The key position always addresses a real table entry.
    a_pos_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(pos_reg) < CW'(KEY_DEPTH))
        else $error("key position beyond the key table");

    // A pending key write always carries a reduced offset.
    a_key_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_valid_reg |-> (wr_key < 5'(rkc_pkg::ALPHA)))
        else $error("pending key offset not reduced modulo 26");

    // The stored length stays within 1..KEY_DEPTH.
    a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (len_eff_reg != '0) && (len_eff_reg <= CW'(KEY_DEPTH)))
        else $error("effective key length out of range");

endmodule
